/* src/double_float_add_sub_assert.svh */
// Assertion macros for the binary64 adder/subtractor.
// Used by double_float_add_sub.sv; no other dependencies.
`ifndef DOUBLE_FLOAT_ADD_SUB_ASSERT_SVH
`define DOUBLE_FLOAT_ADD_SUB_ASSERT_SVH
`ifndef ASSERT_OFF
`define DFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DFA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DFA_ASSERT(label, clk, rst, prop, msg)
`define DFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* src/dfas_pkg.sv */
// Package for the binary64 adder/subtractor: constants, types and helpers.
// No dependencies.
`default_nettype none
package dfas_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned ExpW = 11;
  localparam int unsigned FracW = 52;
  localparam logic [63:0] DefaultNan = 64'hFFF8000000000000;
  localparam logic [63:0] QuietBit = 64'h0008000000000000;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_SUB = 1'b1
  } req_t;

  // Aligned operands handed from the align stage to the normalise stage.
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        sa;
    logic        sb;
    logic [10:0] ea;
    logic [55:0] ma;
    logic [55:0] mb;
  } align_t;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

/* src/dfas_if.sv */
// Valid/ready channel interfaces: operands and request type in, one result word out per handshake.
// Depends on no package.
`default_nettype none
interface dfas_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] first_operand;
  logic [63:0] second_operand;
  modport source (output valid, req_type, first_operand, second_operand, input ready);
  modport sink (input valid, req_type, first_operand, second_operand, output ready);
endinterface

interface dfas_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] sum_bits;
  modport source (output valid, sum_bits, input ready);
  modport sink (input valid, sum_bits, output ready);
endinterface
`default_nettype wire

/* src/dfas_align.sv */
// Unpacking, special cases, operand swap and alignment shift.
// Depends on dfas_pkg.
`default_nettype none
module dfas_align
  import dfas_pkg::*;
(
  input  wire logic        req_type,
  input  wire logic [63:0] first_operand,
  input  wire logic [63:0] second_operand,
  output align_t           aligned
);
  logic [63:0] a, b;
  logic nan_f, nan_s, inf_a, inf_b;
  logic [10:0] ea, eb, ex, ey, d;
  logic [55:0] ma, mb, mx, my, lostmask;
  logic sx, sy, swap;

  always_comb begin
    nan_f = (first_operand[62:52] == '1) && (first_operand[51:0] != '0);
    nan_s = (second_operand[62:52] == '1) && (second_operand[51:0] != '0);
    if (req_t'(req_type) == REQ_SUB) begin
      a = second_operand;
      b = {~first_operand[63], first_operand[62:0]};
    end else begin
      a = first_operand;
      b = second_operand;
    end
    inf_a = a[62:0] == 63'h7FF0000000000000;
    inf_b = b[62:0] == 63'h7FF0000000000000;
    ea = (a[62:52] == '0) ? 11'd1 : a[62:52];
    eb = (b[62:52] == '0) ? 11'd1 : b[62:52];
    ma = {a[62:52] != '0, a[51:0], 3'b000};
    mb = {b[62:52] != '0, b[51:0], 3'b000};
    swap = (eb > ea) || ((eb == ea) && (mb > ma));
    ex = swap ? eb : ea;
    ey = swap ? ea : eb;
    mx = swap ? mb : ma;
    my = swap ? ma : mb;
    sx = swap ? b[63] : a[63];
    sy = swap ? a[63] : b[63];
    d = ex - ey;
    aligned.special = 1'b1;
    aligned.special_bits = '0;
    if (nan_f) aligned.special_bits = first_operand | QuietBit;
    else if (nan_s) aligned.special_bits = second_operand | QuietBit;
    else if (inf_a && inf_b && (a[63] != b[63])) aligned.special_bits = DefaultNan;
    else if (inf_a) aligned.special_bits = a;
    else if (inf_b) aligned.special_bits = b;
    else aligned.special = 1'b0;
    lostmask = '0;
    if (d >= 11'd58) begin
      my = {55'd0, my != '0};
    end else begin
      lostmask = ~(56'hFFFFFFFFFFFFFF << d[5:0]);
      my = (my >> d[5:0]) | {55'd0, (my & lostmask) != '0};
    end
    aligned.sa = sx;
    aligned.sb = sy;
    aligned.ea = ex;
    aligned.ma = mx;
    aligned.mb = my;
  end
endmodule
`default_nettype wire

/* src/dfas_norm.sv */
// Add or subtract of the aligned significands, normalisation and rounding.
// Depends on dfas_pkg.
`default_nettype none
module dfas_norm
  import dfas_pkg::*;
(
  input  align_t            aligned,
  output logic [63:0]       sum_bits
);
  logic [56:0] m;
  logic [55:0] mn;
  logic [12:0] e;
  logic [5:0]  lz, sh;
  logic [53:0] r;
  logic        rup;
  logic [10:0] ef;

  always_comb begin
    if (aligned.sa == aligned.sb) m = {1'b0, aligned.ma} + {1'b0, aligned.mb};
    else m = {1'b0, aligned.ma} - {1'b0, aligned.mb};
    e = {2'b00, aligned.ea};
    mn = m[55:0];
    lz = '0;
    sh = '0;
    if (m[56]) begin
      mn = m[56:1] | {55'd0, m[0]};
      e = e + 13'd1;
    end else begin
      lz = lzc56(m[55:0]);
      if ({7'd0, lz} > e - 13'd1) sh = 6'(e - 13'd1);
      else sh = lz;
      mn = m[55:0] << sh;
      e = e - {7'd0, sh};
    end
    rup = mn[2] && (mn[1] || mn[0] || mn[3]);
    r = {1'b0, mn[55:3]} + {53'd0, rup};
    if (r[53]) begin
      r = r >> 1;
      e = e + 13'd1;
    end
    ef = r[52] ? e[10:0] : 11'd0;
    if (aligned.special) sum_bits = aligned.special_bits;
    else if (m == '0) sum_bits = {(aligned.sa == aligned.sb) && aligned.sa, 63'd0};
    else if (e >= 13'd2047) sum_bits = {aligned.sa, 11'h7FF, 52'd0};
    else sum_bits = {aligned.sa, ef, r[51:0]};
  end
endmodule
`default_nettype wire

/* src/double_float_add_sub.sv */
// IEEE 754 binary64 adder/subtractor, round to nearest even.
// An accepted word is held in the stage-one register, then its result in the result register.
// Throughput: one word per cycle unless the output stalls; the input and result registers form two stages.
// Reset: rst, synchronous and active high, clears both valid flags.
// Depends on dfas_pkg, dfas_if, dfas_align, dfas_norm and the assertion header.
`default_nettype none
`include "double_float_add_sub_assert.svh"
module double_float_add_sub
  import dfas_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dfas_in_if.sink   in_ch,
  dfas_out_if.source out_ch
);
  logic        s1_valid;
  align_t      s1;
  align_t      aligned;
  logic        s2_valid;
  logic [63:0] s2_bits;
  logic [63:0] sum_next;
  logic        s1_ready, s2_ready;

  dfas_align u_align (
    .req_type(in_ch.req_type),
    .first_operand(in_ch.first_operand),
    .second_operand(in_ch.second_operand),
    .aligned(aligned)
  );

  dfas_norm u_norm (
    .aligned(s1),
    .sum_bits(sum_next)
  );

  assign s2_ready = !s2_valid || out_ch.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ch.ready = s1_ready;
  assign out_ch.valid = s2_valid;
  assign out_ch.sum_bits = s2_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_ch.valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
    if (s1_ready && in_ch.valid) s1 <= aligned;
    if (s2_ready && s1_valid) s2_bits <= sum_next;
  end

  `DFA_ASSERT(a_hold, clk, rst, s2_valid && !out_ch.ready |=> s2_valid && $stable(s2_bits), "result word changed while stalled")
  `DFA_ASSERT(a_pass, clk, rst, s1_valid && s2_ready |=> s2_valid, "word lost between stages")
  `DFA_ASSERT(a_ready, clk, rst, !s1_valid |-> in_ch.ready, "empty stage refused a word")
  `DFA_ASSERT_NR(a_rst, clk, rst |=> !s1_valid && !s2_valid, "valid flags not cleared by reset")
endmodule
`default_nettype wire
